// ===== sv/vssl_pkg.sv =====
// ----------------------------------------------------------------------------
// vssl_pkg
// Shared types, register indexes and limit arithmetic for the velocity step
// slew limiter.
// ----------------------------------------------------------------------------
package vssl_pkg;

  localparam int VEL_W       = 24;
  localparam int LIMIT_W     = 23;
  localparam int GAIN_W      = 24;
  localparam int FROZEN_W    = 11;
  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 24;
  localparam int PROD_W      = VEL_W + GAIN_W + 1;
  localparam int FRAC_W      = 16;
  localparam int QUOT_W      = PROD_W - FRAC_W;
  localparam int DIFF_W      = QUOT_W + 1;
  localparam int WIDE_W      = VEL_W + 2;

  localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(65536);

  typedef logic signed [VEL_W-1:0] vel_t;
  typedef logic [LIMIT_W-1:0]      limit_t;
  typedef logic [GAIN_W-1:0]       gain_t;

  // Register indexes on the configuration port.
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_MAX_SPEED_X    = 4'd0,
    REG_MAX_SPEED_Y    = 4'd1,
    REG_MAX_SPEED_TURN = 4'd2,
    REG_MAX_STEP_X     = 4'd3,
    REG_MAX_STEP_Y     = 4'd4,
    REG_MAX_STEP_TURN  = 4'd5,
    REG_STEP_GAIN      = 4'd6,
    REG_FROZEN_COUNT   = 4'd7
  } reg_index_t;

  typedef struct packed {
    limit_t                max_speed_x;
    limit_t                max_speed_y;
    limit_t                max_speed_turn;
    limit_t                max_step_x;
    limit_t                max_step_y;
    limit_t                max_step_turn;
    gain_t                 step_gain;
    logic [FROZEN_W-1:0]   frozen_count;
  } cfg_t;

  // Per-node control flags that travel with an item.
  typedef struct packed {
    logic frozen;
    logic first;
  } node_flags_t;

  // Load strobes of the input register and the result register.
  typedef struct packed {
    logic load1;
    logic load2;
  } stage_ctl_t;

  // Clamp to the neighbor window (unless first node), then to the speed bound.
  function automatic vel_t limit_node(input vel_t v, input vel_t prev, input logic first,
                                      input limit_t speed, input limit_t step);
    logic signed [WIDE_W-1:0] lo;
    logic signed [WIDE_W-1:0] hi;
    logic signed [WIDE_W-1:0] x;
    logic signed [WIDE_W-1:0] spd;
    logic signed [WIDE_W-1:0] stp;
    stp = $signed({{(WIDE_W-LIMIT_W){1'b0}}, step});
    spd = $signed({{(WIDE_W-LIMIT_W){1'b0}}, speed});
    lo  = WIDE_W'(prev) - stp;
    hi  = WIDE_W'(prev) + stp;
    x   = WIDE_W'(v);
    if (!first) begin
      if (x < lo) begin
        x = lo;
      end else if (x > hi) begin
        x = hi;
      end
    end
    if (x < -spd) begin
      x = -spd;
    end else if (x > spd) begin
      x = spd;
    end
    return x[VEL_W-1:0];
  endfunction

  // Saturate a wide difference to the signed velocity range.
  function automatic vel_t sat_vel(input logic signed [DIFF_W-1:0] d);
    logic signed [DIFF_W-1:0] top;
    logic signed [DIFF_W-1:0] bot;
    top = DIFF_W'($signed({1'b0, {(VEL_W-1){1'b1}}}));
    bot = -top - DIFF_W'(1);
    if (d > top) begin
      return top[VEL_W-1:0];
    end else if (d < bot) begin
      return bot[VEL_W-1:0];
    end
    return d[VEL_W-1:0];
  endfunction

endpackage

// ===== sv/vssl_node_if.sv =====
// ----------------------------------------------------------------------------
// vssl_node_if
// Input channel: one trajectory node with its cost gradient per item.
// ----------------------------------------------------------------------------
interface vssl_node_if;
  logic           valid;
  logic           ready;
  logic           first_node;
  vssl_pkg::vel_t vel_x;
  vssl_pkg::vel_t vel_y;
  vssl_pkg::vel_t vel_turn;
  vssl_pkg::vel_t grad_x;
  vssl_pkg::vel_t grad_y;
  vssl_pkg::vel_t grad_turn;

  modport source (
    output valid, first_node, vel_x, vel_y, vel_turn, grad_x, grad_y, grad_turn,
    input  ready
  );
  modport sink (
    input  valid, first_node, vel_x, vel_y, vel_turn, grad_x, grad_y, grad_turn,
    output ready
  );
endinterface

// ===== sv/vssl_result_if.sv =====
// ----------------------------------------------------------------------------
// vssl_result_if
// Output channel: one limited velocity node per item.
// ----------------------------------------------------------------------------
interface vssl_result_if;
  logic           valid;
  logic           ready;
  vssl_pkg::vel_t out_x;
  vssl_pkg::vel_t out_y;
  vssl_pkg::vel_t out_turn;

  modport source (output valid, out_x, out_y, out_turn, input ready);
  modport sink (input valid, out_x, out_y, out_turn, output ready);
endinterface

// ===== sv/vssl_cfg_if.sv =====
// ----------------------------------------------------------------------------
// vssl_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface vssl_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [vssl_pkg::CFG_INDEX_W-1:0]    index;
  logic [vssl_pkg::CFG_DATA_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== sv/velocity_step_slew_limiter.sv =====
// ----------------------------------------------------------------------------
// velocity_step_slew_limiter
// One descent step with slew and magnitude limits on a planar velocity
// trajectory, one node per item.
// ----------------------------------------------------------------------------
// The block takes one trajectory node per clock cycle unless the output holds
// it back. An accepted item passes through two register stages, the input
// register and the result register, and is presented on the output from the
// result register. Between them each axis clamps the node against the previous
// node's first-pass value, takes the descent step with the gain product,
// saturates, and clamps against the previous output. Both per-node feedback
// values are updated in the same cycle that the item reaches the result
// register, so a new node can follow in the very next cycle. The input
// register keeps taking an item while a result waits on the output, and the
// input stalls only when both stages are full and the output is held.
// Configuration registers are written through their own channel, which is
// always ready; write them only while no item is in flight.
// ----------------------------------------------------------------------------
module velocity_step_slew_limiter #(
  parameter int MAX_NODES = 1024
) (
  input logic           clk,
  input logic           rst,
  vssl_node_if.sink     node_in,
  vssl_result_if.source node_out,
  vssl_cfg_if.sink      cfg
);

  vssl_pkg::cfg_t        regs;
  vssl_pkg::node_flags_t flags;
  vssl_pkg::stage_ctl_t  ctl;
  logic                  v1;
  logic                  v2;
  logic                  out_fire;

  // Configuration registers.
  assign cfg.ready = 1'b1;

  vssl_regs u_regs (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg.valid),
    .wr_index (cfg.index),
    .wr_data  (cfg.data),
    .cfg      (regs)
  );

  // Stage handshakes: a stage loads when it is empty or its item moves on.
  assign out_fire       = v2 && node_out.ready;
  assign ctl.load2      = v1 && (!v2 || node_out.ready);
  assign node_in.ready  = !v1 || ctl.load2;
  assign ctl.load1      = node_in.valid && node_in.ready;
  assign node_out.valid = v2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= ctl.load1 || (v1 && !ctl.load2);
      v2 <= ctl.load2 || (v2 && !out_fire);
    end
  end

  // Node index and per-item flags.
  vssl_seq #(
    .MAX_NODES (MAX_NODES)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .accept       (ctl.load1),
    .first_node   (node_in.first_node),
    .frozen_count (regs.frozen_count),
    .flags        (flags)
  );

  // Per-axis datapaths.
  vssl_axis u_axis_x (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .flags_in (flags),
    .vel      (node_in.vel_x),
    .grad     (node_in.grad_x),
    .speed    (regs.max_speed_x),
    .step     (regs.max_step_x),
    .gain     (regs.step_gain),
    .out_val  (node_out.out_x)
  );

  vssl_axis u_axis_y (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .flags_in (flags),
    .vel      (node_in.vel_y),
    .grad     (node_in.grad_y),
    .speed    (regs.max_speed_y),
    .step     (regs.max_step_y),
    .gain     (regs.step_gain),
    .out_val  (node_out.out_y)
  );

  vssl_axis u_axis_turn (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .flags_in (flags),
    .vel      (node_in.vel_turn),
    .grad     (node_in.grad_turn),
    .speed    (regs.max_speed_turn),
    .step     (regs.max_step_turn),
    .gain     (regs.step_gain),
    .out_val  (node_out.out_turn)
  );

`ifndef SYNTH
  // An empty input stage is always ready for an item.
  a_empty_accepts: assert property (@(posedge clk) disable iff (rst)
    !v1 |-> node_in.ready)
    else $error("input stage empty but not ready");

  // A full pipeline with a stalled output takes no item.
  a_full_stalls: assert property (@(posedge clk) disable iff (rst)
    (v1 && v2 && !node_out.ready) |-> !node_in.ready)
    else $error("item accepted into a full pipeline");

  // An accepted item with nothing leaving raises occupancy by one.
  a_occupancy: assert property (@(posedge clk) disable iff (rst)
    (ctl.load1 && !out_fire) |=>
      ($countones({v1, v2}) == $past($countones({v1, v2})) + 1))
    else $error("pipeline occupancy lost an item");
`endif

endmodule

// ===== sv/vssl_regs.sv =====
// ----------------------------------------------------------------------------
// vssl_regs
// Configuration register file for speed and step limits, gain and the
// frozen node count.
// ----------------------------------------------------------------------------
module vssl_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             wr_en,
  input  logic [vssl_pkg::CFG_INDEX_W-1:0] wr_index,
  input  logic [vssl_pkg::CFG_DATA_W-1:0]  wr_data,
  output vssl_pkg::cfg_t                   cfg
);

  // Writes outside the register list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_speed_x    <= '0;
      cfg.max_speed_y    <= '0;
      cfg.max_speed_turn <= '0;
      cfg.max_step_x     <= '0;
      cfg.max_step_y     <= '0;
      cfg.max_step_turn  <= '0;
      cfg.step_gain      <= vssl_pkg::GAIN_RESET;
      cfg.frozen_count   <= '0;
    end else if (wr_en) begin
      case (vssl_pkg::reg_index_t'(wr_index))
        vssl_pkg::REG_MAX_SPEED_X:    cfg.max_speed_x    <= wr_data[vssl_pkg::LIMIT_W-1:0];
        vssl_pkg::REG_MAX_SPEED_Y:    cfg.max_speed_y    <= wr_data[vssl_pkg::LIMIT_W-1:0];
        vssl_pkg::REG_MAX_SPEED_TURN: cfg.max_speed_turn <= wr_data[vssl_pkg::LIMIT_W-1:0];
        vssl_pkg::REG_MAX_STEP_X:     cfg.max_step_x     <= wr_data[vssl_pkg::LIMIT_W-1:0];
        vssl_pkg::REG_MAX_STEP_Y:     cfg.max_step_y     <= wr_data[vssl_pkg::LIMIT_W-1:0];
        vssl_pkg::REG_MAX_STEP_TURN:  cfg.max_step_turn  <= wr_data[vssl_pkg::LIMIT_W-1:0];
        vssl_pkg::REG_STEP_GAIN:      cfg.step_gain      <= wr_data[vssl_pkg::GAIN_W-1:0];
        vssl_pkg::REG_FROZEN_COUNT:   cfg.frozen_count   <= wr_data[vssl_pkg::FROZEN_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== sv/vssl_seq.sv =====
// ----------------------------------------------------------------------------
// vssl_seq
// Node index tracking: restart on the first-node mark, saturate at the
// maximum count, and derive the frozen and first flags of each item.
// ----------------------------------------------------------------------------
module vssl_seq #(
  parameter int MAX_NODES = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  logic                          first_node,
  input  logic [vssl_pkg::FROZEN_W-1:0] frozen_count,
  output vssl_pkg::node_flags_t         flags
);

  localparam int IDX_W = $clog2(MAX_NODES + 1);
  localparam int CMP_W = (IDX_W > vssl_pkg::FROZEN_W) ? IDX_W : vssl_pkg::FROZEN_W;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_NODES);

  logic [IDX_W-1:0] node_index;
  logic [IDX_W-1:0] idx;

  // Index of the item now on the input.
  assign idx          = first_node ? '0 : node_index;
  assign flags.first  = (idx == '0);
  assign flags.frozen = (CMP_W'(idx) < CMP_W'(frozen_count));

  // Advance the index per accepted item, holding at the maximum.
  always_ff @(posedge clk) begin
    if (rst) begin
      node_index <= '0;
    end else if (accept) begin
      node_index <= (idx < IDX_LAST) ? idx + IDX_W'(1) : IDX_LAST;
    end
  end

endmodule

// ===== sv/vssl_axis.sv =====
// ----------------------------------------------------------------------------
// vssl_axis
// One velocity axis: an input register, then the first constraint pass, the
// descent step and the second constraint pass in one pass into the result
// register.
// ----------------------------------------------------------------------------
module vssl_axis (
  input  logic                  clk,
  input  logic                  rst,
  input  vssl_pkg::stage_ctl_t  ctl,
  input  vssl_pkg::node_flags_t flags_in,
  input  vssl_pkg::vel_t        vel,
  input  vssl_pkg::vel_t        grad,
  input  vssl_pkg::limit_t      speed,
  input  vssl_pkg::limit_t      step,
  input  vssl_pkg::gain_t       gain,
  output vssl_pkg::vel_t        out_val
);

  vssl_pkg::vel_t                          s1_vel;
  vssl_pkg::vel_t                          s1_grad;
  vssl_pkg::node_flags_t                   s1_flags;
  vssl_pkg::vel_t                          pre;
  vssl_pkg::vel_t                          last;
  logic signed [vssl_pkg::PROD_W-1:0]      prod;
  logic signed [vssl_pkg::QUOT_W-1:0]      quot;
  vssl_pkg::vel_t                          pre_next;
  logic signed [vssl_pkg::DIFF_W-1:0]      diff;
  vssl_pkg::vel_t                          last_next;

  // Input register.
  always_ff @(posedge clk) begin
    if (ctl.load1) begin
      s1_vel   <= vel;
      s1_grad  <= grad;
      s1_flags <= flags_in;
    end
  end

  // Product with the Q8.16 gain, floored to the gradient's scale, and the pass against the previous node.
  assign prod = vssl_pkg::PROD_W'($signed({1'b0, gain})) * vssl_pkg::PROD_W'(s1_grad);
  assign quot = prod[vssl_pkg::PROD_W-1:vssl_pkg::FRAC_W];
  assign pre_next = s1_flags.frozen ? s1_vel
                  : vssl_pkg::limit_node(s1_vel, pre, s1_flags.first, speed, step);

  // Descent step, saturation and the pass against the previous output.
  assign diff = vssl_pkg::DIFF_W'(pre_next) - vssl_pkg::DIFF_W'(quot);
  assign last_next = s1_flags.frozen ? s1_vel
                   : vssl_pkg::limit_node(vssl_pkg::sat_vel(diff), last, s1_flags.first,
                                          speed, step);

  // Both node histories advance as the item enters the result stage; the
  // previous output node doubles as the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      pre  <= '0;
      last <= '0;
    end else if (ctl.load2) begin
      pre  <= pre_next;
      last <= last_next;
    end
  end

  assign out_val = last;

endmodule
